FILE: src/pss_pkg.sv
// shared types and constants for the pump speed supervisor
package pss_pkg;

  localparam logic [2:0] FN_TICK     = 3'd0;
  localparam logic [2:0] FN_WAIT     = 3'd1;
  localparam logic [2:0] FN_PRIME    = 3'd2;
  localparam logic [2:0] FN_CLEAR    = 3'd3;
  localparam logic [2:0] FN_STOP     = 3'd4;
  localparam logic [2:0] FN_VARIABLE = 3'd5;
  localparam logic [2:0] FN_SET_DUTY = 3'd6;

  localparam logic [1:0] EV_HIGH_START = 2'd1;
  localparam logic [1:0] EV_HIGH_STOP  = 2'd2;

  localparam logic [3:0] MODE_NONE     = 4'd0;
  localparam logic [3:0] MODE_STOP     = 4'd1;
  localparam logic [3:0] MODE_PROBLEM  = 4'd2;
  localparam logic [3:0] MODE_WAITING  = 4'd3;
  localparam logic [3:0] MODE_PRIMING  = 4'd4;
  localparam logic [3:0] MODE_SEEK     = 4'd5;
  localparam logic [3:0] MODE_MIN      = 4'd6;
  localparam logic [3:0] MODE_MAX      = 4'd7;
  localparam logic [3:0] MODE_VARIABLE = 4'd8;

  localparam logic [1:0] STEP_FULL   = 2'd0;
  localparam logic [1:0] STEP_MID    = 2'd1;
  localparam logic [1:0] STEP_DOWN   = 2'd2;
  localparam logic [1:0] STEP_SETTLE = 2'd3;

  localparam logic [6:0]  FULL_DUTY    = 7'd100;
  localparam logic [6:0]  MID_DUTY     = 7'd50;
  localparam logic [6:0]  LOWEST_DUTY  = 7'd10;
  localparam logic [15:0] SETTLE_READS = 16'd6;
  localparam logic [25:0] SUM_MAX      = 26'h3FF_FFFF;
  localparam logic [9:0]  COUNT_MAX    = 10'd1023;
  localparam int          DIV_STEPS    = 26;

  localparam logic [2:0] REG_SLOW      = 3'd0;
  localparam logic [2:0] REG_LOW_FAST  = 3'd1;
  localparam logic [2:0] REG_HIGH_FAST = 3'd2;
  localparam logic [2:0] REG_TARGET    = 3'd3;
  localparam logic [2:0] REG_GOOD      = 3'd4;
  localparam logic [2:0] REG_WINDOW    = 3'd5;
  localparam logic [2:0] REG_PRIMING   = 3'd6;
  localparam logic [2:0] REG_WAIT      = 3'd7;

  localparam logic [15:0] SLOW_RST      = 16'd26041;
  localparam logic [15:0] LOW_FAST_RST  = 16'd19230;
  localparam logic [15:0] HIGH_FAST_RST = 16'd8333;
  localparam logic [15:0] TARGET_RST    = 16'd22321;
  localparam logic [15:0] GOOD_RST      = 16'd22522;
  localparam logic [9:0]  WINDOW_RST    = 10'd500;
  localparam logic [15:0] PRIMING_RST   = 16'd5000;
  localparam logic [15:0] WAIT_RST      = 16'd10000;

  typedef struct packed {
    logic [15:0] slow;
    logic [15:0] low_fast;
    logic [15:0] high_fast;
    logic [15:0] target;
    logic [15:0] good;
    logic [9:0]  window;
    logic [15:0] priming;
    logic [15:0] wait_len;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [1:0]  seek_step;
    logic [6:0]  applied;
    logic [6:0]  working;
    logic [15:0] phase;
    logic [9:0]  window;
    logic [25:0] sum;
    logic [9:0]  count;
    logic        seen_sample;
    logic        seen_good;
    logic        may_step;
    logic        priming_on;
    logic        first_fault;
    logic        err;
    logic        wrote;
  } st_t;

endpackage

FILE: src/pump_speed_supervisor.sv
// pump speed supervisor top level: sequencer, serial divider, apb registers
//
//   channel  direction  handshake                 payload
//   in_      input      in_valid / in_ready       func, level_event, tach_period, ...
//   out_     output     out_valid / out_ready     duty, duty_written, status, minor_error
//   cfg_     apb slave  psel, penable, pready     paddr, pwdata, prdata
//
// a word goes from accept through the pre step to the result; when a tach window closes
// with samples, the average also goes through a 26-step serial divider and a judge step
// in_ready is high only while the sequencer is idle, from the cycle after each result is taken
// a result held by out_ready stalls the next accept
// rst_n is synchronous; it clears the sequencer state and loads the register defaults
module pump_speed_supervisor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [1:0]  in_level_event,
  input  logic [15:0] in_tach_period,
  input  logic        in_tach_valid,
  input  logic [6:0]  in_duty_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_duty,
  output logic        out_duty_written,
  output logic [3:0]  out_status,
  output logic        out_minor_error,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {S_IDLE, S_PRE, S_DIV, S_JUDGE, S_OUT} fsm_t;

  fsm_t            state_r;
  pss_pkg::cfg_t   cfg_r;
  pss_pkg::st_t    st_r;
  pss_pkg::st_t    pre_nxt;
  pss_pkg::st_t    judge_nxt;
  logic            need_div;
  logic [25:0]     dvd_nxt;
  logic [9:0]      dvs_nxt;
  logic [2:0]      func_r;
  logic [1:0]      ev_r;
  logic [15:0]     period_r;
  logic            tvalid_r;
  logic [6:0]      req_r;
  logic [25:0]     quo_r;
  logic [9:0]      rem_r;
  logic [9:0]      dvs_r;
  logic [4:0]      cnt_r;
  logic [10:0]     trial;
  logic            fit;
  logic [2:0]      widx;

  // ---------------- apb registers ----------------
  assign cfg_pready = 1'b1;
  assign widx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow      <= pss_pkg::SLOW_RST;
      cfg_r.low_fast  <= pss_pkg::LOW_FAST_RST;
      cfg_r.high_fast <= pss_pkg::HIGH_FAST_RST;
      cfg_r.target    <= pss_pkg::TARGET_RST;
      cfg_r.good      <= pss_pkg::GOOD_RST;
      cfg_r.window    <= pss_pkg::WINDOW_RST;
      cfg_r.priming   <= pss_pkg::PRIMING_RST;
      cfg_r.wait_len  <= pss_pkg::WAIT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (widx)
        pss_pkg::REG_SLOW:      cfg_r.slow      <= cfg_pwdata[15:0];
        pss_pkg::REG_LOW_FAST:  cfg_r.low_fast  <= cfg_pwdata[15:0];
        pss_pkg::REG_HIGH_FAST: cfg_r.high_fast <= cfg_pwdata[15:0];
        pss_pkg::REG_TARGET:    cfg_r.target    <= cfg_pwdata[15:0];
        pss_pkg::REG_GOOD:      cfg_r.good      <= cfg_pwdata[15:0];
        pss_pkg::REG_WINDOW:    cfg_r.window    <= cfg_pwdata[9:0];
        pss_pkg::REG_PRIMING:   cfg_r.priming   <= cfg_pwdata[15:0];
        pss_pkg::REG_WAIT:      cfg_r.wait_len  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      pss_pkg::REG_SLOW:      cfg_prdata = {16'd0, cfg_r.slow};
      pss_pkg::REG_LOW_FAST:  cfg_prdata = {16'd0, cfg_r.low_fast};
      pss_pkg::REG_HIGH_FAST: cfg_prdata = {16'd0, cfg_r.high_fast};
      pss_pkg::REG_TARGET:    cfg_prdata = {16'd0, cfg_r.target};
      pss_pkg::REG_GOOD:      cfg_prdata = {16'd0, cfg_r.good};
      pss_pkg::REG_WINDOW:    cfg_prdata = {22'd0, cfg_r.window};
      pss_pkg::REG_PRIMING:   cfg_prdata = {16'd0, cfg_r.priming};
      pss_pkg::REG_WAIT:      cfg_prdata = {16'd0, cfg_r.wait_len};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- behavior steps ----------------
  function automatic pss_pkg::st_t fault_f(input pss_pkg::st_t s_in,
                                           input pss_pkg::cfg_t c);
    pss_pkg::st_t s;
    s = s_in;
    if (!s.err) begin
      s.applied = 7'd0;
      s.wrote   = 1'b1;
      if (s.first_fault) begin
        if (s.mode != pss_pkg::MODE_PROBLEM) begin
          s.mode        = pss_pkg::MODE_PROBLEM;
          s.phase       = 16'd0;
          s.window      = 10'd0;
          s.err         = 1'b1;
          s.priming_on  = 1'b0;
          s.first_fault = 1'b0;
        end
      end else begin
        // a fault never arrives while waiting, so this only enters the wait
        s.first_fault = 1'b1;
        if (s.mode != pss_pkg::MODE_WAITING) begin
          s.mode   = pss_pkg::MODE_WAITING;
          s.phase  = 16'd0;
          s.window = 10'd0;
        end else if (s.phase < c.wait_len) begin
          s.phase = s.phase + 16'd1;
        end
      end
    end
    return s;
  endfunction

  function automatic pss_pkg::st_t seek_f(input pss_pkg::st_t s_in,
                                          input pss_pkg::cfg_t c);
    pss_pkg::st_t s;
    s = s_in;
    if (s.mode != pss_pkg::MODE_SEEK) begin
      s.mode      = pss_pkg::MODE_SEEK;
      s.seek_step = pss_pkg::STEP_FULL;
      s.working   = pss_pkg::MID_DUTY;
      s.phase     = 16'd0;
      s.window    = 10'd0;
    end
    if (s.may_step) begin
      s.may_step = 1'b0;
      case (s.seek_step)
        pss_pkg::STEP_FULL: begin
          s.applied   = pss_pkg::FULL_DUTY;
          s.wrote     = 1'b1;
          s.seek_step = pss_pkg::STEP_MID;
        end
        pss_pkg::STEP_MID: begin
          s.applied   = pss_pkg::MID_DUTY;
          s.wrote     = 1'b1;
          s.seek_step = pss_pkg::STEP_DOWN;
        end
        pss_pkg::STEP_DOWN: begin
          if (s.working != 7'd0) s.working = s.working - 7'd1;
          if (s.working < pss_pkg::LOWEST_DUTY) begin
            s = fault_f(s, c);
          end else begin
            s.applied = s.working;
            s.wrote   = 1'b1;
          end
        end
        default: ;
      endcase
    end
    return s;
  endfunction

  function automatic pss_pkg::st_t prime_f(input pss_pkg::st_t s_in,
                                           input pss_pkg::cfg_t c);
    pss_pkg::st_t s;
    s = s_in;
    if (s.mode != pss_pkg::MODE_PRIMING) begin
      s.mode   = pss_pkg::MODE_PRIMING;
      s.phase  = 16'd0;
      s.window = 10'd0;
    end
    s.phase = s.phase + 16'd1;
    if (s.phase < c.priming) begin
      if (!s.priming_on) begin
        s.applied    = pss_pkg::FULL_DUTY;
        s.wrote      = 1'b1;
        s.priming_on = 1'b1;
      end
    end else begin
      s.phase      = 16'd0;
      s.window     = 10'd0;
      s.priming_on = 1'b0;
      s = seek_f(s, c);
    end
    return s;
  endfunction

  function automatic pss_pkg::st_t start_f(input pss_pkg::st_t s_in,
                                           input pss_pkg::cfg_t c,
                                           input logic with_wait);
    pss_pkg::st_t s;
    s = s_in;
    if (!with_wait) begin
      s.phase  = 16'd0;
      s.window = 10'd0;
      s = prime_f(s, c);
    end else if (s.mode != pss_pkg::MODE_WAITING) begin
      s.mode   = pss_pkg::MODE_WAITING;
      s.phase  = 16'd0;
      s.window = 10'd0;
    end else if (s.phase < c.wait_len) begin
      s.phase = s.phase + 16'd1;
    end else begin
      s.phase  = 16'd0;
      s.window = 10'd0;
      s = prime_f(s, c);
    end
    return s;
  endfunction

  // six-read settling; the caller works out whether it passes
  function automatic pss_pkg::st_t settle_f(input pss_pkg::st_t s_in,
                                            input pss_pkg::cfg_t c,
                                            input logic [25:0] avg);
    pss_pkg::st_t s;
    s = s_in;
    s.phase = s.phase + 16'd1;
    if (s.phase < pss_pkg::SETTLE_READS) begin
      if (avg <= {10'd0, c.good}) s.seen_good = 1'b1;
    end else begin
      if (!s.seen_good) begin
        if (s.working < pss_pkg::FULL_DUTY) s.working = s.working + 7'd1;
        s.applied = s.working;
        s.wrote   = 1'b1;
      end
      s.seen_good = 1'b0;
      s.phase     = 16'd0;
    end
    return s;
  endfunction

  function automatic pss_pkg::st_t judge_f(input pss_pkg::st_t s_in,
                                           input pss_pkg::cfg_t c,
                                           input logic [25:0] avg);
    pss_pkg::st_t s;
    logic         slow;
    logic         ok;
    logic [15:0]  ph1;
    s    = s_in;
    slow = avg > {10'd0, c.slow};
    ph1  = s.phase + 16'd1;
    ok   = (ph1 >= pss_pkg::SETTLE_READS) && s.seen_good;
    if (s.mode == pss_pkg::MODE_MAX) begin
      if (avg < {10'd0, c.high_fast} || slow) s = fault_f(s, c);
    end else if (s.mode == pss_pkg::MODE_MIN) begin
      if (avg < {10'd0, c.low_fast} || slow) s = fault_f(s, c);
      else s = settle_f(s, c, avg);
    end else if (s.mode == pss_pkg::MODE_SEEK) begin
      s.may_step = 1'b1;
      if (s.seek_step == pss_pkg::STEP_DOWN) begin
        if (avg > {10'd0, c.target}) begin
          s.seek_step = pss_pkg::STEP_SETTLE;
          s.phase     = 16'd0;
          s.window    = 10'd0;
        end
      end else if (s.seek_step == pss_pkg::STEP_SETTLE) begin
        if (avg < {10'd0, c.low_fast} || slow) begin
          s = fault_f(s, c);
        end else begin
          s = settle_f(s, c, avg);
          if (ok) begin
            s.mode        = pss_pkg::MODE_MIN;
            s.first_fault = 1'b0;
          end
        end
      end
    end
    return s;
  endfunction

  // command and tick handling up to the window average
  always_comb begin
    pss_pkg::st_t s;
    logic [26:0]  sum_w;
    s        = st_r;
    s.wrote  = 1'b0;
    need_div = 1'b0;
    dvd_nxt  = st_r.sum;
    dvs_nxt  = st_r.count;
    sum_w    = 27'd0;
    case (func_r)
      pss_pkg::FN_TICK: begin
        case (s.mode)
          pss_pkg::MODE_PROBLEM:  s = fault_f(s, cfg_r);
          pss_pkg::MODE_WAITING:  s = start_f(s, cfg_r, 1'b1);
          pss_pkg::MODE_PRIMING:  s = prime_f(s, cfg_r);
          pss_pkg::MODE_SEEK:     s = seek_f(s, cfg_r);
          pss_pkg::MODE_STOP:     ;
          pss_pkg::MODE_VARIABLE: ;
          default: begin
            if (ev_r == pss_pkg::EV_HIGH_START) begin
              if (s.mode != pss_pkg::MODE_MAX) begin
                s.applied = pss_pkg::FULL_DUTY;
                s.wrote   = 1'b1;
                s.mode    = pss_pkg::MODE_MAX;
              end
            end else if (ev_r == pss_pkg::EV_HIGH_STOP) begin
              if (s.mode != pss_pkg::MODE_MIN) s = seek_f(s, cfg_r);
            end else begin
              s.applied = 7'd0;
              s.wrote   = 1'b1;
              s.mode    = pss_pkg::MODE_NONE;
            end
          end
        endcase
        if (s.mode == pss_pkg::MODE_SEEK || s.mode == pss_pkg::MODE_MIN ||
            s.mode == pss_pkg::MODE_MAX) begin
          s.window = s.window + 10'd1;
          if (tvalid_r) begin
            sum_w = {1'b0, s.sum} + {11'd0, period_r};
            s.sum = sum_w[26] ? pss_pkg::SUM_MAX : sum_w[25:0];
            if (s.count < pss_pkg::COUNT_MAX) s.count = s.count + 10'd1;
            s.seen_sample = 1'b1;
          end
          if (s.window >= cfg_r.window) begin
            // with samples the average goes through the divider and is judged after
            if (s.seen_sample && s.count != 10'd0) begin
              need_div = 1'b1;
              dvd_nxt  = s.sum;
              dvs_nxt  = s.count;
            end else begin
              s = fault_f(s, cfg_r);
            end
            s.seen_sample = 1'b0;
            s.sum         = 26'd0;
            s.count       = 10'd0;
            s.window      = 10'd0;
          end
        end
      end
      pss_pkg::FN_WAIT:  s = start_f(s, cfg_r, 1'b1);
      pss_pkg::FN_PRIME: s = start_f(s, cfg_r, 1'b0);
      pss_pkg::FN_CLEAR: begin
        s.first_fault = 1'b0;
        s.err         = 1'b0;
        s = prime_f(s, cfg_r);
      end
      pss_pkg::FN_STOP: begin
        if (s.mode != pss_pkg::MODE_STOP) begin
          s.mode    = pss_pkg::MODE_STOP;
          s.applied = 7'd0;
          s.wrote   = 1'b1;
        end
      end
      pss_pkg::FN_VARIABLE: s.mode = pss_pkg::MODE_VARIABLE;
      pss_pkg::FN_SET_DUTY: begin
        s.applied = (req_r > pss_pkg::FULL_DUTY) ? pss_pkg::FULL_DUTY : req_r;
        s.wrote   = 1'b1;
      end
      default: ;
    endcase
    pre_nxt = s;
  end

  assign judge_nxt = judge_f(st_r, cfg_r, quo_r);

  // restoring divider step, one quotient bit per cycle
  assign trial = {rem_r, quo_r[25]};
  assign fit   = trial >= {1'b0, dvs_r};

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= '0;
      cnt_r   <= 5'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_PRE;
        end
        S_PRE: begin
          st_r <= pre_nxt;
          if (need_div) begin
            quo_r   <= dvd_nxt;
            dvs_r   <= dvs_nxt;
            rem_r   <= 10'd0;
            cnt_r   <= 5'(pss_pkg::DIV_STEPS - 1);
            state_r <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          rem_r <= fit ? 10'(trial - {1'b0, dvs_r}) : trial[9:0];
          quo_r <= {quo_r[24:0], fit};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= S_JUDGE;
        end
        S_JUDGE: begin
          st_r    <= judge_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r   <= in_func;
      ev_r     <= in_level_event;
      period_r <= in_tach_period;
      tvalid_r <= in_tach_valid;
      req_r    <= in_duty_request;
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_duty         = st_r.applied;
  assign out_duty_written = st_r.wrote;
  assign out_status       = st_r.mode;
  assign out_minor_error  = st_r.err;

  // ---------------- checks ----------------
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_PRE))
    else $error("accepted word did not start processing");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dvs_r != 10'd0))
    else $error("divider started with zero sample count");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r != 5'd0) |=> (state_r == S_DIV))
    else $error("divider left early");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty <= pss_pkg::FULL_DUTY))
    else $error("duty above full scale");

endmodule

FILE: sim/pump_speed_supervisor_test.sv
// testbench for the pump speed supervisor: directed and random words checked against a predictor
module pump_speed_supervisor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FN_UNUSED  = 3'd7;
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_UNKNOWN = 2'd3;

  typedef struct {
    logic [2:0]  func;
    logic [1:0]  ev;
    logic [15:0] period;
    logic        tach_ok;
    logic [6:0]  req;
  } pump_word_t;

  typedef struct {
    logic [6:0] duty;
    logic       written;
    logic [3:0] status;
    logic       minor;
  } pump_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_func = '0;
  logic [1:0] in_level_event = '0;
  logic [15:0] in_tach_period = '0;
  logic in_tach_valid = 1'b0;
  logic [6:0] in_duty_request = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [6:0] out_duty;
  logic out_duty_written;
  logic [3:0] out_status;
  logic out_minor_error;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pump_speed_supervisor DUT (.*);

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [15:0] lim_slow, lim_low_fast, lim_high_fast, lim_target, lim_good;
  logic [9:0]  win_len;
  logic [15:0] prime_len, wait_len;

  // predictor copy of the state
  logic [3:0]  pump_mode;
  logic [1:0]  search_step;
  logic [6:0]  duty_now, duty_work;
  logic [15:0] phase_cnt;
  logic [9:0]  window_cnt;
  logic [25:0] tach_sum;
  logic [9:0]  tach_cnt;
  logic got_sample, got_good, step_armed, prime_active, fault_once, err_held;
  logic duty_touched;

  pump_status_t expected_status[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  bit idle_on = 1'b1;
  int hold_req = 0;

  function automatic void put_duty(logic [6:0] d);
    duty_now = d;
    duty_touched = 1'b1;
  endfunction

  function automatic void raise_working();
    if (duty_work < pss_pkg::FULL_DUTY) duty_work++;
    put_duty(duty_work);
  endfunction

  function automatic void prime_step();
    if (pump_mode != pss_pkg::MODE_PRIMING) begin
      pump_mode = pss_pkg::MODE_PRIMING;
      phase_cnt = '0;
      window_cnt = '0;
    end
    phase_cnt = phase_cnt + 16'd1;
    if (phase_cnt < prime_len) begin
      if (!prime_active) begin
        put_duty(pss_pkg::FULL_DUTY);
        prime_active = 1'b1;
      end
    end else begin
      phase_cnt = '0;
      window_cnt = '0;
      prime_active = 1'b0;
      search_min();
    end
  endfunction

  function automatic void start_run(bit with_wait);
    if (!with_wait) begin
      phase_cnt = '0;
      window_cnt = '0;
      prime_step();
    end else if (pump_mode != pss_pkg::MODE_WAITING) begin
      pump_mode = pss_pkg::MODE_WAITING;
      phase_cnt = '0;
      window_cnt = '0;
    end else if (phase_cnt < wait_len) begin
      phase_cnt = phase_cnt + 16'd1;
    end else begin
      phase_cnt = '0;
      window_cnt = '0;
      prime_step();
    end
  endfunction

  function automatic void take_fault();
    if (err_held) return;
    put_duty('0);
    if (fault_once) begin
      if (pump_mode != pss_pkg::MODE_PROBLEM) begin
        pump_mode = pss_pkg::MODE_PROBLEM;
        phase_cnt = '0;
        window_cnt = '0;
        err_held = 1'b1;
        prime_active = 1'b0;
        fault_once = 1'b0;
      end
    end else begin
      fault_once = 1'b1;
      start_run(1'b1);
    end
  endfunction

  function automatic void search_min();
    if (pump_mode != pss_pkg::MODE_SEEK) begin
      pump_mode = pss_pkg::MODE_SEEK;
      search_step = pss_pkg::STEP_FULL;
      duty_work = pss_pkg::MID_DUTY;
      phase_cnt = '0;
      window_cnt = '0;
    end
    if (!step_armed) return;
    step_armed = 1'b0;
    if (search_step == pss_pkg::STEP_FULL) begin
      put_duty(pss_pkg::FULL_DUTY);
      search_step = pss_pkg::STEP_MID;
    end else if (search_step == pss_pkg::STEP_MID) begin
      put_duty(pss_pkg::MID_DUTY);
      search_step = pss_pkg::STEP_DOWN;
    end else if (search_step == pss_pkg::STEP_DOWN) begin
      if (duty_work > 0) duty_work--;
      if (duty_work < pss_pkg::LOWEST_DUTY) take_fault();
      else put_duty(duty_work);
    end
  endfunction

  // six averages per round; true when one of the first five was good
  function automatic bit settle_round(logic [25:0] avg);
    bit ok = 1'b0;
    phase_cnt = phase_cnt + 16'd1;
    if (phase_cnt < pss_pkg::SETTLE_READS) begin
      if (avg <= lim_good) got_good = 1'b1;
    end else begin
      if (!got_good) raise_working();
      else ok = 1'b1;
      got_good = 1'b0;
      phase_cnt = '0;
    end
    return ok;
  endfunction

  function automatic void judge_average(logic [25:0] avg);
    if (pump_mode == pss_pkg::MODE_MAX) begin
      if (avg < lim_high_fast || avg > lim_slow) take_fault();
    end else if (pump_mode == pss_pkg::MODE_MIN) begin
      if (avg < lim_low_fast || avg > lim_slow) take_fault();
      else void'(settle_round(avg));
    end else if (pump_mode == pss_pkg::MODE_SEEK) begin
      step_armed = 1'b1;
      if (search_step == pss_pkg::STEP_DOWN) begin
        if (avg > lim_target) begin
          search_step = pss_pkg::STEP_SETTLE;
          phase_cnt = '0;
          window_cnt = '0;
        end
      end else if (search_step == pss_pkg::STEP_SETTLE) begin
        if (avg < lim_low_fast || avg > lim_slow) take_fault();
        else if (settle_round(avg)) begin
          pump_mode = pss_pkg::MODE_MIN;
          fault_once = 1'b0;
        end
      end
    end
  endfunction

  function automatic void watch_tach(logic [15:0] period, logic ok);
    logic [26:0] s;
    window_cnt = window_cnt + 10'd1;
    if (ok) begin
      s = tach_sum + period;
      tach_sum = (s > pss_pkg::SUM_MAX) ? pss_pkg::SUM_MAX : s[25:0];
      if (tach_cnt < pss_pkg::COUNT_MAX) tach_cnt++;
      got_sample = 1'b1;
    end
    if (window_cnt < win_len) return;
    if (got_sample && tach_cnt != 0) judge_average(tach_sum / tach_cnt);
    else take_fault();
    got_sample = 1'b0;
    tach_sum = '0;
    tach_cnt = '0;
    window_cnt = '0;
  endfunction

  function automatic void run_tick(pump_word_t w);
    case (pump_mode)
      pss_pkg::MODE_PROBLEM: take_fault();
      pss_pkg::MODE_WAITING: start_run(1'b1);
      pss_pkg::MODE_PRIMING: prime_step();
      pss_pkg::MODE_SEEK: search_min();
      pss_pkg::MODE_STOP, pss_pkg::MODE_VARIABLE: ;
      default: begin
        if (w.ev == pss_pkg::EV_HIGH_START) begin
          if (pump_mode != pss_pkg::MODE_MAX) begin
            put_duty(pss_pkg::FULL_DUTY);
            pump_mode = pss_pkg::MODE_MAX;
          end
        end else if (w.ev == pss_pkg::EV_HIGH_STOP) begin
          if (pump_mode != pss_pkg::MODE_MIN) search_min();
        end else begin
          put_duty('0);
          pump_mode = pss_pkg::MODE_NONE;
        end
      end
    endcase
    if (pump_mode == pss_pkg::MODE_SEEK || pump_mode == pss_pkg::MODE_MIN ||
        pump_mode == pss_pkg::MODE_MAX)
      watch_tach(w.period, w.tach_ok);
  endfunction

  function automatic pump_status_t predict_status(pump_word_t w);
    pump_status_t r;
    duty_touched = 1'b0;
    case (w.func)
      pss_pkg::FN_TICK: run_tick(w);
      pss_pkg::FN_WAIT: start_run(1'b1);
      pss_pkg::FN_PRIME: start_run(1'b0);
      pss_pkg::FN_CLEAR: begin
        fault_once = 1'b0;
        err_held = 1'b0;
        prime_step();
      end
      pss_pkg::FN_STOP: begin
        if (pump_mode != pss_pkg::MODE_STOP) begin
          pump_mode = pss_pkg::MODE_STOP;
          put_duty('0);
        end
      end
      pss_pkg::FN_VARIABLE: pump_mode = pss_pkg::MODE_VARIABLE;
      pss_pkg::FN_SET_DUTY:
        put_duty(w.req > pss_pkg::FULL_DUTY ? pss_pkg::FULL_DUTY : w.req);
      default: ;
    endcase
    r.duty = duty_now;
    r.written = duty_touched;
    r.status = pump_mode;
    r.minor = err_held;
    return r;
  endfunction

  function automatic void reset_predictor();
    lim_slow = pss_pkg::SLOW_RST; lim_low_fast = pss_pkg::LOW_FAST_RST;
    lim_high_fast = pss_pkg::HIGH_FAST_RST;
    lim_target = pss_pkg::TARGET_RST; lim_good = pss_pkg::GOOD_RST;
    win_len = pss_pkg::WINDOW_RST;
    prime_len = pss_pkg::PRIMING_RST; wait_len = pss_pkg::WAIT_RST;
    pump_mode = pss_pkg::MODE_NONE; search_step = pss_pkg::STEP_FULL;
    duty_now = '0; duty_work = '0; phase_cnt = '0; window_cnt = '0;
    tach_sum = '0; tach_cnt = '0;
    got_sample = 0; got_good = 0; step_armed = 0; prime_active = 0;
    fault_once = 0; err_held = 0; duty_touched = 0;
  endfunction

  task automatic send_word(pump_word_t w);
    in_valid <= 1'b1;
    in_func <= w.func;
    in_level_event <= w.ev;
    in_tach_period <= w.period;
    in_tach_valid <= w.tach_ok;
    in_duty_request <= w.req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_status.push_back(predict_status(w));
    words_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  function automatic pump_word_t make_word(logic [2:0] f, logic [1:0] e, logic [15:0] p,
                                           logic t, logic [6:0] q);
    pump_word_t w;
    w.func = f; w.ev = e; w.period = p; w.tach_ok = t; w.req = q;
    return w;
  endfunction

  // tach periods mostly near the configured limits, some anywhere
  function automatic pump_word_t rand_tick();
    int lo, hi;
    logic [15:0] p;
    lo = (lim_low_fast > 3000) ? lim_low_fast - 3000 : 0;
    hi = (lim_slow < 62535) ? lim_slow + 3000 : 65535;
    if (lo > hi) lo = 0;
    p = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(lo, hi)) : 16'($urandom);
    return make_word(pss_pkg::FN_TICK, 2'($urandom_range(0, 3)), p,
                     $urandom_range(0, 9) != 0, 7'($urandom));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      pss_pkg::REG_SLOW: lim_slow = val[15:0];
      pss_pkg::REG_LOW_FAST: lim_low_fast = val[15:0];
      pss_pkg::REG_HIGH_FAST: lim_high_fast = val[15:0];
      pss_pkg::REG_TARGET: lim_target = val[15:0];
      pss_pkg::REG_GOOD: lim_good = val[15:0];
      pss_pkg::REG_WINDOW: win_len = val[9:0];
      pss_pkg::REG_PRIMING: prime_len = val[15:0];
      pss_pkg::REG_WAIT: wait_len = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(int slow, int lowf, int highf, int tgt, int good,
                               int win, int prim, int wt);
    drain();
    reg_write(pss_pkg::REG_SLOW, slow);
    reg_write(pss_pkg::REG_LOW_FAST, lowf);
    reg_write(pss_pkg::REG_HIGH_FAST, highf);
    reg_write(pss_pkg::REG_TARGET, tgt);
    reg_write(pss_pkg::REG_GOOD, good);
    reg_write(pss_pkg::REG_WINDOW, win);
    reg_write(pss_pkg::REG_PRIMING, prim);
    reg_write(pss_pkg::REG_WAIT, wt);
    @(posedge clk);
  endtask

  // a command to get a sequence going, then mostly ticks with stray commands mixed in
  task automatic run_sequences(int n_words);
    int sent = 0;
    int len;
    logic [2:0] kick;
    while (sent < n_words) begin
      kick = ($urandom_range(0, 4) == 0) ? pss_pkg::FN_CLEAR : 3'($urandom_range(0, 2));
      if ($urandom_range(0, 5) == 0) begin
        send_word(make_word(pss_pkg::FN_STOP, EV_NONE, '0, 1'b0, '0));
        sent++;
      end
      send_word(make_word(kick, 2'($urandom_range(1, 2)), 16'($urandom),
                          1'($urandom), 7'($urandom)));
      sent++;
      len = $urandom_range(15, 70);
      repeat (len) begin
        if ($urandom_range(0, 19) == 0)
          send_word(make_word(3'($urandom_range(0, 7)), 2'($urandom), 16'($urandom),
                              1'($urandom), 7'($urandom)));
        else
          send_word(rand_tick());
        sent++;
      end
    end
  endtask

  task automatic test_commands();
    send_word(make_word(FN_UNUSED, EV_NONE, '0, 1'b0, '0));
    send_word(make_word(pss_pkg::FN_TICK, EV_UNKNOWN, 16'hFFFF, 1'b1, 7'h7F));
    send_word(make_word(pss_pkg::FN_TICK, pss_pkg::EV_HIGH_START, 16'd20000, 1'b1, '0));
    send_word(make_word(pss_pkg::FN_TICK, pss_pkg::EV_HIGH_START, 16'h0000, 1'b1, '0));
    send_word(make_word(pss_pkg::FN_TICK, EV_NONE, 16'hFFFF, 1'b0, '0));
    send_word(make_word(pss_pkg::FN_TICK, pss_pkg::EV_HIGH_STOP, 16'hFFFF, 1'b1, '0));
    send_word(make_word(pss_pkg::FN_SET_DUTY, EV_NONE, '0, 1'b0, 7'd127));
    send_word(make_word(pss_pkg::FN_SET_DUTY, EV_NONE, '0, 1'b0, 7'd101));
    send_word(make_word(pss_pkg::FN_SET_DUTY, EV_NONE, '0, 1'b0, 7'd100));
    send_word(make_word(pss_pkg::FN_SET_DUTY, EV_NONE, '0, 1'b0, 7'd0));
    send_word(make_word(pss_pkg::FN_VARIABLE, EV_NONE, '0, 1'b0, '0));
    send_word(make_word(pss_pkg::FN_TICK, pss_pkg::EV_HIGH_START, 16'd5000, 1'b1, '0));
    send_word(make_word(pss_pkg::FN_STOP, EV_NONE, '0, 1'b0, '0));
    send_word(make_word(pss_pkg::FN_STOP, EV_NONE, '0, 1'b0, '0));
    send_word(make_word(pss_pkg::FN_WAIT, EV_NONE, '0, 1'b0, '0));
    send_word(make_word(pss_pkg::FN_WAIT, EV_NONE, '0, 1'b0, '0));
    send_word(make_word(pss_pkg::FN_PRIME, EV_NONE, '0, 1'b0, '0));
    send_word(make_word(pss_pkg::FN_TICK, EV_NONE, 16'h5555, 1'b1, 7'h55));
    send_word(make_word(pss_pkg::FN_CLEAR, EV_NONE, 16'hAAAA, 1'b1, 7'h2A));
    send_word(make_word(FN_UNUSED, EV_UNKNOWN, 16'hFFFF, 1'b1, 7'h7F));
  endtask

  task automatic test_short_windows();
    load_settings(26041, 19230, 8333, 22321, 22522, 3, 5, 4);
    run_sequences(450);
  endtask

  task automatic test_open_limits();
    load_settings(65535, 0, 0, 1, 65535, 1, 1, 0);
    run_sequences(250);
  endtask

  task automatic test_closed_limits();
    load_settings(0, 65535, 65535, 65535, 0, 1023, 65535, 65535);
    run_sequences(150);
  endtask

  task automatic test_backpressure();
    load_settings(24000, 20000, 9000, 21000, 23000, 2, 3, 2);
    hold_req = 300;
    run_sequences(130);
  endtask

  task automatic test_full_rate();
    load_settings(25000, 18000, 10000, 22000, 21000, 4, 6, 3);
    idle_on = 1'b0;
    run_sequences(400);
  endtask

  // receiver side: random stalls, and one long hold when asked
  always @(posedge clk) begin
    if (hold_req > 0) begin
      out_ready <= 1'b0;
      repeat (hold_req) @(posedge clk);
      hold_req = 0;
      out_ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        pump_status_t e;
        e = expected_status.pop_front();
        words_checked++;
        if (out_duty !== e.duty) begin
          $error("duty expected %0d got %0d", e.duty, out_duty);
          errors++;
        end
        if (out_duty_written !== e.written) begin
          $error("duty_written expected %0d got %0d", e.written, out_duty_written);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_status);
          errors++;
        end
        if (out_minor_error !== e.minor) begin
          $error("minor_error expected %0d got %0d", e.minor, out_minor_error);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    reset_predictor();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_short_windows();
    test_open_limits();
    test_closed_limits();
    test_backpressure();
    test_full_rate();
    drain();
    $display("sent %0d words, checked %0d results over five register settings", words_sent,
             words_checked);
    $display("covered all commands, wait/prime/seek/min/max sequences, faults and a long stall");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
